[rtl/lpct_pkg.sv]
// Shared types, constants and codes of the lazy page commit tracker.
package lpct_pkg;

    // Table geometry
    localparam int DEF_MAX_REGIONS = 8;
    localparam int PAGE_BYTES      = 4096;
    localparam int PAGE_SHIFT      = $clog2(PAGE_BYTES);
    localparam int MAX_PAGES       = 64;
    localparam int PIDX_W          = (MAX_PAGES > 1) ? $clog2(MAX_PAGES) : 1;

    // Field widths
    localparam int BASE_W  = 64;
    localparam int BYTES_W = 32;
    localparam int SIZE_W  = 19;
    localparam int PAGES_W = 7;
    localparam int COUNT_W = 4;
    localparam int ID_W    = 3;
    localparam int IDX_W   = 4;

    // Largest region that is accepted, in bytes
    localparam logic [BYTES_W-1:0] MAX_BYTES = BYTES_W'(MAX_PAGES * PAGE_BYTES);

    // Default region held in entry 0 after reset
    localparam logic [BASE_W-1:0]  INIT_BASE  = 64'h0000_0000_043C_0000;
    localparam logic [SIZE_W-1:0]  INIT_SIZE  = 19'h30000;
    localparam logic [PAGES_W-1:0] INIT_PAGES =
        PAGES_W'((32'h30000 + PAGE_BYTES - 1) / PAGE_BYTES);

    typedef enum logic [1:0] {
        CMD_ADD   = 2'd0,
        CMD_TOUCH = 2'd1,
        CMD_QUERY = 2'd2,
        CMD_RSVD  = 2'd3
    } cmd_t;

    typedef enum logic [2:0] {
        ST_ADDED     = 3'd0,
        ST_REFUSED   = 3'd1,
        ST_TOO_LARGE = 3'd2,
        ST_COMMITTED = 3'd3,
        ST_MISS      = 3'd4,
        ST_QUERY_OK  = 3'd5,
        ST_BAD_INDEX = 3'd6
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ADD,
        S_SCAN,
        S_QRD,
        S_QEV,
        S_DONE
    } seq_state_t;

    // Region descriptor, written only by add
    typedef struct packed {
        logic [BASE_W-1:0]  base;
        logic [SIZE_W-1:0]  size;
        logic [PAGES_W-1:0] pages;
    } desc_t;

    // Commit state, updated by touch
    typedef struct packed {
        logic [MAX_PAGES-1:0] mask;
        logic [PAGES_W-1:0]   count;
    } cmt_t;

    // One result beat
    typedef struct packed {
        status_t            status;
        logic [ID_W-1:0]    region_id;
        logic [BASE_W-1:0]  entry_base;
        logic [SIZE_W-1:0]  entry_size;
        logic [PAGES_W-1:0] entry_total_pages;
        logic [PAGES_W-1:0] entry_committed_pages;
        logic [COUNT_W-1:0] entry_count;
    } result_t;

endpackage

[rtl/lpct_req_if.sv]
// Command channel of the lazy page commit tracker.
interface lpct_req_if import lpct_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [1:0]         cmd;
    logic [BASE_W-1:0]  address;
    logic [BYTES_W-1:0] region_bytes;
    logic [IDX_W-1:0]   entry_index;

    modport source (
        output valid, cmd, address, region_bytes, entry_index,
        input  ready
    );
    modport sink (
        input  valid, cmd, address, region_bytes, entry_index,
        output ready
    );
endinterface

[rtl/lpct_rsp_if.sv]
// Result channel of the lazy page commit tracker.
interface lpct_rsp_if import lpct_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [2:0]         status;
    logic [ID_W-1:0]    region_id;
    logic [BASE_W-1:0]  entry_base;
    logic [SIZE_W-1:0]  entry_size;
    logic [PAGES_W-1:0] entry_total_pages;
    logic [PAGES_W-1:0] entry_committed_pages;
    logic [COUNT_W-1:0] entry_count;

    modport source (
        output valid, status, region_id, entry_base, entry_size,
               entry_total_pages, entry_committed_pages, entry_count,
        input  ready
    );
    modport sink (
        input  valid, status, region_id, entry_base, entry_size,
               entry_total_pages, entry_committed_pages, entry_count,
        output ready
    );
endinterface

[rtl/lpct_table.sv]
// Region descriptor and commit memories with one registered read port.
module lpct_table import lpct_pkg::*; #(
    parameter int MAX_REGIONS = DEF_MAX_REGIONS,
    localparam int IW = (MAX_REGIONS > 1) ? $clog2(MAX_REGIONS) : 1
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          rd_en,
    input  logic [IW-1:0] rd_addr,
    input  logic          desc_we,
    input  logic          cmt_we,
    input  logic [IW-1:0] wr_addr,
    input  desc_t         desc_wdata,
    input  cmt_t          cmt_wdata,
    output desc_t         rd_desc,
    output cmt_t          rd_cmt
);

    desc_t desc_mem [MAX_REGIONS];
    cmt_t  cmt_mem  [MAX_REGIONS];

    logic [MAX_REGIONS-1:0] desc_vld_reg;
    logic [MAX_REGIONS-1:0] cmt_vld_reg;
    desc_t                  desc_q_reg;
    cmt_t                   cmt_q_reg;
    logic                   dvld_q_reg;
    logic                   cvld_q_reg;
    logic                   zero_q_reg;

    // Memory arrays: write port and registered read port
    always_ff @(posedge clk)
    begin
        if (desc_we)
        begin
            desc_mem[wr_addr] <= desc_wdata;
        end
        if (cmt_we)
        begin
            cmt_mem[wr_addr] <= cmt_wdata;
        end
        if (rd_en)
        begin
            desc_q_reg <= desc_mem[rd_addr];
            cmt_q_reg  <= cmt_mem[rd_addr];
        end
    end

    // Written flags per entry; an unwritten entry reads as its reset value
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            desc_vld_reg <= '0;
            cmt_vld_reg  <= '0;
            dvld_q_reg   <= 1'b0;
            cvld_q_reg   <= 1'b0;
            zero_q_reg   <= 1'b0;
        end
        else
        begin
            if (desc_we)
            begin
                desc_vld_reg[wr_addr] <= 1'b1;
            end
            if (cmt_we)
            begin
                cmt_vld_reg[wr_addr] <= 1'b1;
            end
            if (rd_en)
            begin
                dvld_q_reg <= desc_vld_reg[rd_addr];
                cvld_q_reg <= cmt_vld_reg[rd_addr];
                zero_q_reg <= (rd_addr == '0);
            end
        end
    end

    // Reset image: entry 0 holds the default region, the rest are zero
    always_comb
    begin
        if (dvld_q_reg)
        begin
            rd_desc = desc_q_reg;
        end
        else if (zero_q_reg)
        begin
            rd_desc = '{base: INIT_BASE, size: INIT_SIZE, pages: INIT_PAGES};
        end
        else
        begin
            rd_desc = '0;
        end
        rd_cmt = cvld_q_reg ? cmt_q_reg : '0;
    end

endmodule

[rtl/lpct_seq.sv]
// Command sequencer: add check, table scan for touch, query read-out.
module lpct_seq import lpct_pkg::*; #(
    parameter int MAX_REGIONS = DEF_MAX_REGIONS,
    localparam int IW = (MAX_REGIONS > 1) ? $clog2(MAX_REGIONS) : 1,
    localparam int CW = $clog2(MAX_REGIONS + 1)
) (
    input  logic          clk,
    input  logic          rst_n,
    lpct_req_if.sink      req,
    output logic          rd_en,
    output logic [IW-1:0] rd_addr,
    output logic          desc_we,
    output logic          cmt_we,
    output logic [IW-1:0] wr_addr,
    output desc_t         desc_wdata,
    output cmt_t          cmt_wdata,
    input  desc_t         rd_desc,
    input  cmt_t          rd_cmt,
    output logic          res_valid,
    input  logic          res_ready,
    output result_t       res_data
);

    seq_state_t         state_reg, state_next;
    logic [CW-1:0]      fill_reg, fill_next;
    logic [CW-1:0]      scan_reg, scan_next;
    logic [IW-1:0]      chk_reg, chk_next;
    logic               pend_reg, pend_next;
    result_t            res_reg, res_next;

    logic [BASE_W-1:0]  addr_reg;
    logic [BYTES_W-1:0] bytes_reg;
    logic [IDX_W-1:0]   idx_reg;

    logic [BASE_W:0]      diff;
    logic                 in_range;
    logic [PIDX_W-1:0]    page;
    logic [MAX_PAGES-1:0] page_bit;
    logic                 page_new;
    cmt_t                 cmt_upd;
    logic [BYTES_W:0]     round_up;
    logic [PAGES_W-1:0]   add_pages;
    logic                 scan_issue;
    logic                 query_ok;

    function automatic result_t blank_result(status_t st, logic [COUNT_W-1:0] cnt);
        result_t r;
        r             = '0;
        r.status      = st;
        r.entry_count = cnt;
        return r;
    endfunction

    // Range test of the entry read last cycle, without wraparound
    assign diff     = {1'b0, addr_reg} - {1'b0, rd_desc.base};
    assign in_range = !diff[BASE_W] && (diff[BASE_W-1:SIZE_W] == '0)
                      && (diff[SIZE_W-1:0] < rd_desc.size);
    assign page     = diff[PAGE_SHIFT +: PIDX_W];
    assign page_bit = MAX_PAGES'(1) << page;
    assign page_new = ((rd_cmt.mask & page_bit) == '0);

    always_comb
    begin
        cmt_upd = rd_cmt;
        if (page_new)
        begin
            cmt_upd.mask  = rd_cmt.mask | page_bit;
            cmt_upd.count = rd_cmt.count + PAGES_W'(1);
        end
    end

    // Page count of a new region, rounded up
    assign round_up  = {1'b0, bytes_reg} + (BYTES_W + 1)'(PAGE_BYTES - 1);
    assign add_pages = round_up[PAGE_SHIFT +: PAGES_W];

    assign scan_issue = (scan_reg < fill_reg);
    assign query_ok   = ({1'b0, idx_reg} < (IDX_W + 1)'(fill_reg));

    // State and control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            fill_reg  <= CW'(1);
            scan_reg  <= '0;
            chk_reg   <= '0;
            pend_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            fill_reg  <= fill_next;
            scan_reg  <= scan_next;
            chk_reg   <= chk_next;
            pend_reg  <= pend_next;
        end
    end

    // Command payload and result
    always_ff @(posedge clk)
    begin
        if (req.valid && req.ready)
        begin
            addr_reg  <= req.address;
            bytes_reg <= req.region_bytes;
            idx_reg   <= req.entry_index;
        end
        res_reg <= res_next;
    end

    // Next state, memory control and result
    always_comb
    begin
        state_next = state_reg;
        fill_next  = fill_reg;
        scan_next  = scan_reg;
        chk_next   = chk_reg;
        pend_next  = 1'b0;
        res_next   = res_reg;
        rd_en      = 1'b0;
        rd_addr    = scan_reg[IW-1:0];
        desc_we    = 1'b0;
        cmt_we     = 1'b0;
        wr_addr    = chk_reg;
        desc_wdata = '{base: addr_reg, size: bytes_reg[SIZE_W-1:0], pages: add_pages};
        cmt_wdata  = cmt_upd;
        req.ready  = (state_reg == S_IDLE);
        res_valid  = (state_reg == S_DONE);

        unique case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    unique case (cmd_t'(req.cmd))
                        CMD_ADD:   state_next = S_ADD;
                        CMD_TOUCH:
                        begin
                            scan_next  = '0;
                            state_next = S_SCAN;
                        end
                        CMD_QUERY: state_next = S_QRD;
                        CMD_RSVD:
                        begin
                            res_next   = blank_result(ST_BAD_INDEX, COUNT_W'(fill_reg));
                            state_next = S_DONE;
                        end
                        default:   state_next = S_IDLE;
                    endcase
                end
            end

            S_ADD:
            begin
                if ((fill_reg >= CW'(MAX_REGIONS)) || (bytes_reg == '0))
                begin
                    res_next = blank_result(ST_REFUSED, COUNT_W'(fill_reg));
                end
                else if (bytes_reg > MAX_BYTES)
                begin
                    res_next = blank_result(ST_TOO_LARGE, COUNT_W'(fill_reg));
                end
                else
                begin
                    desc_we   = 1'b1;
                    cmt_we    = 1'b1;
                    wr_addr   = fill_reg[IW-1:0];
                    cmt_wdata = '0;
                    fill_next = fill_reg + CW'(1);
                    res_next  = blank_result(ST_ADDED, COUNT_W'(fill_reg + CW'(1)));
                    res_next.region_id         = ID_W'(fill_reg);
                    res_next.entry_total_pages = add_pages;
                end
                state_next = S_DONE;
            end

            S_SCAN:
            begin
                // Read entry scan_reg while checking entry chk_reg
                rd_en     = scan_issue;
                pend_next = scan_issue;
                chk_next  = scan_reg[IW-1:0];
                if (scan_issue)
                begin
                    scan_next = scan_reg + CW'(1);
                end
                if (pend_reg && in_range)
                begin
                    cmt_we   = 1'b1;
                    wr_addr  = chk_reg;
                    res_next = blank_result(ST_COMMITTED, COUNT_W'(fill_reg));
                    res_next.region_id             = ID_W'(chk_reg);
                    res_next.entry_committed_pages = cmt_upd.count;
                    pend_next  = 1'b0;
                    state_next = S_DONE;
                end
                else if (!scan_issue)
                begin
                    res_next   = blank_result(ST_MISS, COUNT_W'(fill_reg));
                    state_next = S_DONE;
                end
            end

            S_QRD:
            begin
                rd_addr = idx_reg[IW-1:0];
                if (query_ok)
                begin
                    rd_en      = 1'b1;
                    state_next = S_QEV;
                end
                else
                begin
                    res_next   = blank_result(ST_BAD_INDEX, COUNT_W'(fill_reg));
                    state_next = S_DONE;
                end
            end

            S_QEV:
            begin
                res_next = blank_result(ST_QUERY_OK, COUNT_W'(fill_reg));
                res_next.region_id             = ID_W'(idx_reg);
                res_next.entry_base            = rd_desc.base;
                res_next.entry_size            = rd_desc.size;
                res_next.entry_total_pages     = rd_desc.pages;
                res_next.entry_committed_pages = rd_cmt.count;
                state_next = S_DONE;
            end

            S_DONE:
            begin
                if (res_ready)
                begin
                    state_next = S_IDLE;
                end
            end

            default: state_next = S_IDLE;
        endcase
    end

    assign res_data = res_reg;

endmodule

[rtl/lazy_page_commit_tracker_core.sv]
// Top level of the lazy page commit tracker: sequencer, tables, result register.
//
// Tracks up to MAX_REGIONS memory regions of at most 64 pages of 4096 bytes,
// with a committed-page bitmask and count per region; entry 0 holds the
// default region (base 0x043C0000, 0x30000 bytes, 48 pages) after reset.
// Each command beat gives exactly one result beat. Commands run one at a
// time. Touch cost is set by the scan over the regions in the table, one
// table entry per cycle through the single read port of the descriptor
// and commit memories, with the range compare in the cycle after the read.
// A result register at the output lets the next command be taken while
// the last result waits.
module lazy_page_commit_tracker_core import lpct_pkg::*; #(
    parameter int MAX_REGIONS = DEF_MAX_REGIONS
) (
    input  logic     clk,
    input  logic     rst_n,
    lpct_req_if.sink req,
    lpct_rsp_if.source rsp
);

    localparam int IW = (MAX_REGIONS > 1) ? $clog2(MAX_REGIONS) : 1;

    logic          rd_en;
    logic [IW-1:0] rd_addr;
    logic          desc_we;
    logic          cmt_we;
    logic [IW-1:0] wr_addr;
    desc_t         desc_wdata;
    cmt_t          cmt_wdata;
    desc_t         rd_desc;
    cmt_t          rd_cmt;
    logic          res_valid;
    logic          res_ready;
    result_t       res_data;

    logic          out_valid_reg;
    result_t       out_data_reg;

    lpct_seq #(.MAX_REGIONS(MAX_REGIONS)) u_seq (
        .clk        (clk),
        .rst_n      (rst_n),
        .req        (req),
        .rd_en      (rd_en),
        .rd_addr    (rd_addr),
        .desc_we    (desc_we),
        .cmt_we     (cmt_we),
        .wr_addr    (wr_addr),
        .desc_wdata (desc_wdata),
        .cmt_wdata  (cmt_wdata),
        .rd_desc    (rd_desc),
        .rd_cmt     (rd_cmt),
        .res_valid  (res_valid),
        .res_ready  (res_ready),
        .res_data   (res_data)
    );

    lpct_table #(.MAX_REGIONS(MAX_REGIONS)) u_table (
        .clk        (clk),
        .rst_n      (rst_n),
        .rd_en      (rd_en),
        .rd_addr    (rd_addr),
        .desc_we    (desc_we),
        .cmt_we     (cmt_we),
        .wr_addr    (wr_addr),
        .desc_wdata (desc_wdata),
        .cmt_wdata  (cmt_wdata),
        .rd_desc    (rd_desc),
        .rd_cmt     (rd_cmt)
    );

    // Result register: loads when empty or being drained
    assign res_ready = !out_valid_reg || rsp.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res_ready)
        begin
            out_valid_reg <= res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid && res_ready)
        begin
            out_data_reg <= res_data;
        end
    end

    assign rsp.valid                 = out_valid_reg;
    assign rsp.status                = out_data_reg.status;
    assign rsp.region_id             = out_data_reg.region_id;
    assign rsp.entry_base            = out_data_reg.entry_base;
    assign rsp.entry_size            = out_data_reg.entry_size;
    assign rsp.entry_total_pages     = out_data_reg.entry_total_pages;
    assign rsp.entry_committed_pages = out_data_reg.entry_committed_pages;
    assign rsp.entry_count           = out_data_reg.entry_count;

`ifndef NO_ASSERTIONS
    // A pending result in the sequencer holds until the result register takes it
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(res_data))
        else $error("sequencer result changed while stalled");

    // No command is taken while the sequencer still holds a result
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        req.valid && req.ready |-> !res_valid)
        else $error("command accepted with a result pending");

    // A committed touch always reports at least one committed page
    a_commit_count: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && (rsp.status == ST_COMMITTED) |-> rsp.entry_committed_pages != '0)
        else $error("touch hit with zero committed pages");

    // A successful add lands in the slot just below the new fill
    a_add_slot: assert property (@(posedge clk) disable iff (!rst_n)
        (MAX_REGIONS <= 8) && rsp.valid && (rsp.status == ST_ADDED)
        |-> rsp.entry_count == COUNT_W'(rsp.region_id) + COUNT_W'(1))
        else $error("added region id does not match table fill");
`endif

endmodule
